// ===== design/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

    localparam int CELL_ADDR_W = 16;

    localparam logic [2:0] OP_PUT_CUR  = 3'd0;
    localparam logic [2:0] OP_PUT_POS  = 3'd1;
    localparam logic [2:0] OP_SET_ATTR = 3'd2;
    localparam logic [2:0] OP_CLEAR    = 3'd3;
    localparam logic [2:0] OP_SCROLL   = 3'd4;
    localparam logic [2:0] OP_READ     = 3'd5;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h0F;

    typedef enum logic [3:0] {
        K_PUT_CUR,
        K_NEWLINE,
        K_PUT_POS,
        K_POS_ERR,
        K_SET_ATTR,
        K_CLEAR,
        K_SCROLL,
        K_READ,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [7:0]             char_code;
        logic [7:0]             attribute;
        logic [CELL_ADDR_W-1:0] addr;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SCROLL,
        ST_BLANK,
        ST_READ
    } t_state;

endpackage

`default_nettype wire

// ===== design/tcw_if.sv =====
`default_nettype none

interface tcw_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [7:0] column;
    logic [7:0] row;

    modport source (output valid, operation, char_code, attribute, column, row,
                    input ready);
    modport sink   (input valid, operation, char_code, attribute, column, row,
                    output ready);
endinterface

interface tcw_res_if;
    logic        valid;
    logic        ready;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        status;
    logic [15:0] cell_value;

    modport source (output valid, cursor_col, cursor_row, status, cell_value,
                    input ready);
    modport sink   (input valid, cursor_col, cursor_row, status, cell_value,
                    output ready);
endinterface

`default_nettype wire

// ===== design/tcw_front.sv =====
`default_nettype none

module tcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    tcw_req_if.sink       i_req,
    input  wire logic     i_q_ready,
    output logic          o_push,
    output tcw_pkg::t_cmd o_cmd
);
    import tcw_pkg::*;

    logic in_range;

    assign in_range = (i_req.column < 8'(COLUMNS)) && (i_req.row < 8'(ROWS));

    assign i_req.ready = i_q_ready;
    assign o_push      = i_req.valid && i_q_ready;

    always_comb begin
        o_cmd.char_code = i_req.char_code;
        o_cmd.attribute = i_req.attribute;
        o_cmd.addr      = CELL_ADDR_W'(i_req.row) * CELL_ADDR_W'(COLUMNS)
                        + CELL_ADDR_W'(i_req.column);
        case (i_req.operation)
            OP_PUT_CUR: begin
                o_cmd.kind = (i_req.char_code == NEWLINE_CODE) ? K_NEWLINE : K_PUT_CUR;
            end
            OP_PUT_POS: begin
                o_cmd.kind = in_range ? K_PUT_POS : K_POS_ERR;
            end
            OP_SET_ATTR: begin
                o_cmd.kind = K_SET_ATTR;
            end
            OP_CLEAR: begin
                o_cmd.kind = K_CLEAR;
            end
            OP_SCROLL: begin
                o_cmd.kind = K_SCROLL;
            end
            OP_READ: begin
                o_cmd.kind = in_range ? K_READ : K_POS_ERR;
            end
            default: begin
                o_cmd.kind = K_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/tcw_queue.sv =====
`default_nettype none

module tcw_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tcw_pkg::t_cmd  i_cmd,
    output logic                o_ready,
    output logic                o_valid,
    output tcw_pkg::t_cmd       o_cmd,
    input  wire logic           i_pop
);
    import tcw_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== design/tcw_back.sv =====
`default_nettype none

module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire tcw_pkg::t_cmd i_cmd,
    output logic               o_pop,
    tcw_res_if.source          o_res
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] MOVE_CNT  = AW'(COLUMNS * (ROWS - 1));
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);

    logic [15:0] r_cells [CELL_COUNT];
    logic [15:0] r_rd_data;

    t_state      r_state,    n_state;
    logic [AW-1:0] r_cnt,    n_cnt;
    logic        r_mv_valid, n_mv_valid;
    logic [AW-1:0] r_mv_addr, n_mv_addr;
    logic [7:0]  r_cur_x,    n_cur_x;
    logic [7:0]  r_cur_y,    n_cur_y;
    logic [AW-1:0] r_row_base, n_row_base;
    logic [7:0]  r_attr,     n_attr;
    logic        r_out_valid, n_out_valid;
    logic [6:0]  r_out_col,  n_out_col;
    logic [4:0]  r_out_row,  n_out_row;
    logic        r_out_status, n_out_status;
    logic [15:0] r_out_cell, n_out_cell;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [15:0]   mem_wd;
    logic [AW-1:0] rd_addr;
    logic          out_free;
    logic          done;
    logic          done_status;
    logic [15:0]   done_cell;
    logic [15:0]   fill_cell;

    assign out_free  = !r_out_valid || o_res.ready;
    assign fill_cell = {r_attr, SPACE_CODE};

    assign o_res.valid      = r_out_valid;
    assign o_res.cursor_col = r_out_col;
    assign o_res.cursor_row = r_out_row;
    assign o_res.status     = r_out_status;
    assign o_res.cell_value = r_out_cell;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_mv_valid   = r_mv_valid;
        n_mv_addr    = r_mv_addr;
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_row_base   = r_row_base;
        n_attr       = r_attr;
        mem_we       = 1'b0;
        mem_wa       = r_cnt;
        mem_wd       = fill_cell;
        rd_addr      = '0;
        o_pop        = 1'b0;
        done         = 1'b0;
        done_status  = 1'b0;
        done_cell    = 16'd0;

        case (r_state)
            ST_INIT: begin
                mem_we = 1'b1;
                if (r_cnt == LAST_CELL) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            ST_CLEAR, ST_BLANK: begin
                mem_we = 1'b1;
                if (r_cnt == LAST_CELL) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                    done    = 1'b1;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            ST_SCROLL: begin
                if (r_mv_valid) begin
                    mem_we = 1'b1;
                    mem_wa = r_mv_addr;
                    mem_wd = r_rd_data;
                end
                if (r_cnt != MOVE_CNT) begin
                    rd_addr    = r_cnt + ROW_STEP;
                    n_mv_valid = 1'b1;
                    n_mv_addr  = r_cnt;
                    n_cnt      = r_cnt + AW'(1);
                end else begin
                    n_mv_valid = 1'b0;
                    n_state    = ST_BLANK;
                end
            end
            ST_READ: begin
                n_state   = ST_IDLE;
                done      = 1'b1;
                done_cell = r_rd_data;
            end
            ST_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        K_PUT_CUR, K_NEWLINE: begin
                            if (i_cmd.kind == K_PUT_CUR) begin
                                mem_we = 1'b1;
                                mem_wa = r_row_base + AW'(r_cur_x);
                                mem_wd = {r_attr, i_cmd.char_code};
                            end
                            if ((i_cmd.kind == K_PUT_CUR) && (r_cur_x != 8'(COLUMNS - 1))) begin
                                n_cur_x = r_cur_x + 8'd1;
                                done    = 1'b1;
                            end else begin
                                n_cur_x = 8'd0;
                                if (r_cur_y == 8'(ROWS - 1)) begin
                                    n_state    = ST_SCROLL;
                                    n_cnt      = '0;
                                    n_mv_valid = 1'b0;
                                end else begin
                                    n_cur_y    = r_cur_y + 8'd1;
                                    n_row_base = r_row_base + ROW_STEP;
                                    done       = 1'b1;
                                end
                            end
                        end
                        K_PUT_POS: begin
                            mem_we = 1'b1;
                            mem_wa = i_cmd.addr[AW-1:0];
                            mem_wd = {i_cmd.attribute, i_cmd.char_code};
                            done   = 1'b1;
                        end
                        K_POS_ERR: begin
                            done        = 1'b1;
                            done_status = 1'b1;
                        end
                        K_SET_ATTR: begin
                            n_attr = i_cmd.attribute;
                            done   = 1'b1;
                        end
                        K_CLEAR: begin
                            n_attr     = i_cmd.attribute;
                            n_cur_x    = 8'd0;
                            n_cur_y    = 8'd0;
                            n_row_base = '0;
                            n_cnt      = '0;
                            n_state    = ST_CLEAR;
                        end
                        K_SCROLL: begin
                            n_cnt      = '0;
                            n_mv_valid = 1'b0;
                            n_state    = ST_SCROLL;
                        end
                        K_READ: begin
                            rd_addr = i_cmd.addr[AW-1:0];
                            n_state = ST_READ;
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;
        n_out_status = r_out_status;
        n_out_cell   = r_out_cell;
        if (done) begin
            n_out_valid  = 1'b1;
            n_out_col    = n_cur_x[6:0];
            n_out_row    = n_cur_y[4:0];
            n_out_status = done_status;
            n_out_cell   = done_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cnt       <= '0;
            r_mv_valid  <= 1'b0;
            r_cur_x     <= 8'd0;
            r_cur_y     <= 8'd0;
            r_row_base  <= '0;
            r_attr      <= RESET_ATTR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_mv_valid  <= n_mv_valid;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_row_base  <= n_row_base;
            r_attr      <= n_attr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mv_addr    <= n_mv_addr;
        r_out_col    <= n_out_col;
        r_out_row    <= n_out_row;
        r_out_status <= n_out_status;
        r_out_cell   <= n_out_cell;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_cells[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_cells[rd_addr];
    end

`ifndef SYNTHESIS
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_x < 8'(COLUMNS)) && (r_cur_y < 8'(ROWS)))
        else $error("Cursor left the screen.");

    a_row_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_base == AW'(int'(r_cur_y) * COLUMNS))
        else $error("Row base does not match the cursor row.");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_out_valid)
        else $error("A result is pending while a command is still running.");

    a_scroll_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCROLL) && (r_cnt != MOVE_CNT)) |=> r_mv_valid)
        else $error("Scroll copy lost a pending write.");
`endif

endmodule

`default_nettype wire

// ===== design/text_console_writer.sv =====
// A put, newline, set attribute, out-of-range or unused request waits in the queue,
// executes and has its result registered; one request completes per cycle at best,
// while the result side is ready and no clear, scroll or read runs. Read cell also
// waits for the registered memory read. Clear blanks every cell; scroll copies each
// row up, then blanks the bottom row; a put or newline leaving the bottom row scrolls.
// After reset all cells are blanked before a request executes; up to two can queue.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcw_req_if.sink   i_req,
    tcw_res_if.source o_res
);
    import tcw_pkg::*;

    logic push;
    logic q_ready;
    logic q_valid;
    logic pop;
    t_cmd front_cmd;
    t_cmd q_cmd;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_req     (i_req),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (front_cmd)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

// ===== test/text_console_writer_checker.sv =====
`default_nettype none

module text_console_writer_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_ready,
    input  wire logic [2:0]  i_req_operation,
    input  wire logic [7:0]  i_req_char_code,
    input  wire logic [7:0]  i_req_attribute,
    input  wire logic [7:0]  i_req_column,
    input  wire logic [7:0]  i_req_row,
    input  wire logic        i_res_valid,
    input  wire logic        i_res_ready,
    input  wire logic [6:0]  i_res_cursor_col,
    input  wire logic [4:0]  i_res_cursor_row,
    input  wire logic        i_res_status,
    input  wire logic [15:0] i_res_cell_value,
    output int               o_fail_count,
    output int               o_pending
);
    import tcw_pkg::*;

    localparam int CELL_COUNT  = COLUMNS * ROWS;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic        status;
        logic [15:0] cell_value;
    } t_outcome;

    logic [15:0] screen [CELL_COUNT];
    int          cur_col;
    int          cur_row;
    logic [7:0]  text_attr;
    t_outcome    outcome_q [$];
    int          mismatches;

    initial begin
        mismatches   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void fill_screen(logic [15:0] value);
        int i;
        for (i = 0; i < CELL_COUNT; i++) begin
            screen[i] = value;
        end
    endfunction

    function automatic void scroll_screen();
        int i;
        for (i = 0; i < COLUMNS * (ROWS - 1); i++) begin
            screen[i] = screen[i + COLUMNS];
        end
        for (i = COLUMNS * (ROWS - 1); i < CELL_COUNT; i++) begin
            screen[i] = {text_attr, SPACE_CODE};
        end
    endfunction

    function automatic void next_line();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
            scroll_screen();
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic t_outcome predict_request(logic [2:0] op, logic [7:0] ch,
                                                 logic [7:0] attr, logic [7:0] col,
                                                 logic [7:0] row);
        t_outcome outcome;
        logic     off_screen;
        outcome    = '0;
        off_screen = (int'(col) >= COLUMNS) || (int'(row) >= ROWS);
        case (op)
            OP_PUT_CUR: begin
                if (ch == NEWLINE_CODE) begin
                    next_line();
                end else begin
                    screen[cur_row * COLUMNS + cur_col] = {text_attr, ch};
                    cur_col++;
                    if (cur_col >= COLUMNS) begin
                        next_line();
                    end
                end
            end
            OP_PUT_POS: begin
                if (off_screen) begin
                    outcome.status = 1'b1;
                end else begin
                    screen[int'(row) * COLUMNS + int'(col)] = {attr, ch};
                end
            end
            OP_SET_ATTR: begin
                text_attr = attr;
            end
            OP_CLEAR: begin
                text_attr = attr;
                fill_screen({attr, SPACE_CODE});
                cur_col = 0;
                cur_row = 0;
            end
            OP_SCROLL: begin
                scroll_screen();
            end
            OP_READ: begin
                if (off_screen) begin
                    outcome.status = 1'b1;
                end else begin
                    outcome.cell_value = screen[int'(row) * COLUMNS + int'(col)];
                end
            end
            default: begin
            end
        endcase
        outcome.cursor_col = 7'(cur_col);
        outcome.cursor_row = 5'(cur_row);
        return outcome;
    endfunction

    always @(posedge i_clk) begin : compare_proc
        t_outcome got;
        t_outcome want;
        if (!i_rst_n) begin
            fill_screen({RESET_ATTR, SPACE_CODE});
            cur_col   = 0;
            cur_row   = 0;
            text_attr = RESET_ATTR;
            outcome_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = {i_res_cursor_col, i_res_cursor_row, i_res_status,
                       i_res_cell_value};
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("checker: result with no request pending:",
                                 " col %0d row %0d status %0d cell %h",
                                 got.cursor_col, got.cursor_row, got.status,
                                 got.cell_value);
                    end
                end else begin
                    want = outcome_q.pop_front();
                    if (got.cursor_col !== want.cursor_col ||
                        got.cursor_row !== want.cursor_row ||
                        got.status !== want.status ||
                        got.cell_value !== want.cell_value) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("checker: mismatch at %0t:", $realtime,
                                     " expected col %0d row %0d status %0d cell %h,",
                                     want.cursor_col, want.cursor_row, want.status,
                                     want.cell_value,
                                     " got col %0d row %0d status %0d cell %h",
                                     got.cursor_col, got.cursor_row, got.status,
                                     got.cell_value);
                        end
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                outcome_q.push_back(predict_request(i_req_operation, i_req_char_code,
                                                    i_req_attribute, i_req_column,
                                                    i_req_row));
            end
        end
        o_pending    <= outcome_q.size();
        o_fail_count <= mismatches;
    end

endmodule

`default_nettype wire

// ===== test/text_console_writer_tb.sv =====
`default_nettype none

module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int ITEM_TARGET  = 1275;
    localparam int LONG_HOLD    = 500;
    localparam int WATCH_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 2200;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic steady;
    logic hold_request;
    int   sent_count;
    int   fail_count;
    int   pending;

    tcw_req_if req_ch ();
    tcw_res_if res_ch ();

    always #5 i_clk = ~i_clk;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    text_console_writer_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (req_ch.valid),
        .i_req_ready      (req_ch.ready),
        .i_req_operation  (req_ch.operation),
        .i_req_char_code  (req_ch.char_code),
        .i_req_attribute  (req_ch.attribute),
        .i_req_column     (req_ch.column),
        .i_req_row        (req_ch.row),
        .i_res_valid      (res_ch.valid),
        .i_res_ready      (res_ch.ready),
        .i_res_cursor_col (res_ch.cursor_col),
        .i_res_cursor_row (res_ch.cursor_row),
        .i_res_status     (res_ch.status),
        .i_res_cell_value (res_ch.cell_value),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 80) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [7:0] ch,
                                input logic [7:0] attr, input logic [7:0] col,
                                input logic [7:0] row);
        int gap;
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.char_code <= ch;
        req_ch.attribute <= attr;
        req_ch.column    <= col;
        req_ch.row       <= row;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
        sent_count++;
        if (!steady && $urandom_range(0, 99) < 25) begin
            gap = gap_len();
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_text(input int count, input int newline_pct);
        int         i;
        logic [7:0] ch;
        for (i = 0; i < count; i++) begin
            ch = ($urandom_range(0, 99) < newline_pct) ? NEWLINE_CODE : 8'($urandom);
            send_request(OP_PUT_CUR, ch, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic send_random_single();
        int         pick;
        logic [2:0] op;
        logic [7:0] col;
        logic [7:0] row;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) begin
            col = 8'($urandom);
            row = 8'($urandom);
        end else begin
            col = 8'($urandom_range(0, COLUMNS - 1));
            row = 8'($urandom_range(0, ROWS - 1));
        end
        if (pick < 30) begin
            op = OP_PUT_POS;
        end else if (pick < 65) begin
            op = OP_READ;
        end else if (pick < 77) begin
            op = OP_SET_ATTR;
        end else if (pick < 85) begin
            op = OP_SCROLL;
        end else if (pick < 89) begin
            op = OP_CLEAR;
        end else if (pick < 95) begin
            op = pick[0] ? OP_SPARE_A : OP_SPARE_B;
        end else begin
            op = OP_PUT_CUR;
        end
        send_request(op, 8'($urandom), 8'($urandom), col, row);
    endtask

    initial begin : result_drain
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD - 1;
                res_ch.ready <= 1'b0;
            end else if (!steady && $urandom_range(0, 99) < 20) begin
                stall_left   = gap_len() - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stall_watch
        int quiet;
        quiet = 0;
        while (quiet < WATCH_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int   pick;
        logic hold_done;
        logic pause_done;
        steady       = 1'b0;
        hold_request = 1'b0;
        sent_count   = 0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_PUT_CUR;
        req_ch.char_code <= 8'h00;
        req_ch.attribute <= 8'h00;
        req_ch.column    <= 8'h00;
        req_ch.row       <= 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(OP_PUT_CUR, 8'h41, 8'h00, 8'h00, 8'h00);
        send_request(OP_PUT_CUR, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_PUT_CUR, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_request(OP_PUT_CUR, NEWLINE_CODE, 8'h00, 8'h00, 8'h00);
        send_request(OP_SET_ATTR, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(OP_PUT_CUR, 8'h55, 8'h00, 8'h00, 8'h00);
        send_request(OP_SET_ATTR, 8'h00, 8'hFF, 8'h00, 8'h00);
        send_request(OP_PUT_POS, 8'hFF, 8'hFF, 8'd0, 8'd0);
        send_request(OP_PUT_POS, 8'h00, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 1));
        send_request(OP_PUT_POS, 8'h41, 8'h12, 8'(COLUMNS), 8'd0);
        send_request(OP_PUT_POS, 8'h41, 8'h12, 8'd0, 8'(ROWS));
        send_request(OP_PUT_POS, 8'h41, 8'h12, 8'hFF, 8'hFF);
        send_request(OP_READ, 8'h00, 8'h00, 8'd0, 8'd0);
        send_request(OP_READ, 8'h00, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 1));
        send_request(OP_READ, 8'h00, 8'h00, 8'(COLUMNS), 8'd0);
        send_request(OP_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_SPARE_A, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_SPARE_B, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(OP_SCROLL, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(OP_READ, 8'h00, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 2));
        send_request(OP_READ, 8'h00, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 1));
        send_request(OP_CLEAR, 8'h00, 8'hA5, 8'h00, 8'h00);
        send_request(OP_READ, 8'h00, 8'h00, 8'd40, 8'd12);
        wait_for_results();

        while (sent_count < ITEM_TARGET) begin
            if ($urandom_range(0, 19) == 0) begin
                steady = ~steady;
            end
            // The result side holds off while requests keep coming, so the block fills up.
            if (!hold_done && sent_count >= 450) begin
                hold_done    = 1'b1;
                hold_request = 1'b1;
                steady       = 1'b1;
                send_text(60, 8);
                steady       = 1'b0;
            end
            if (!pause_done && sent_count >= 800) begin
                pause_done = 1'b1;
                wait_for_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                send_text($urandom_range(20, 26), 100);
            end else if (pick < 17) begin
                send_text($urandom_range(3, 30), 8);
            end else begin
                send_random_single();
            end
        end
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== text_console_writer.f =====
design/tcw_pkg.sv
design/tcw_if.sv
design/tcw_front.sv
design/tcw_queue.sv
design/tcw_back.sv
design/text_console_writer.sv
test/text_console_writer_checker.sv
test/text_console_writer_tb.sv
